[design/aimd_arc_pkg.sv]
// Types and constants shared by the AIMD admission rate control files.
package aimd_arc_pkg;

   localparam int unsigned RateWidth    = 32;
   localparam int unsigned FracWidth    = 16;
   localparam int unsigned GoodWidth    = 31;
   localparam int unsigned CsrIdxWidth  = 3;

   // Q0.16 one and the largest usable headroom share (0.99).
   localparam logic [FracWidth:0]   Q16_ONE      = 17'd65536;
   localparam logic [FracWidth-1:0] HEADROOM_MAX = 16'd64880;

   // Register reset values.
   localparam logic [RateWidth-1:0] FLOOR_RATE_RST      = 32'd1000;
   localparam logic [FracWidth-1:0] HEADROOM_SHARE_RST  = 16'd6554;
   localparam logic [FracWidth-1:0] DECREASE_FACTOR_RST = 16'd32768;
   localparam logic [FracWidth-1:0] LOSS_THRESHOLD_RST  = 16'd6554;
   localparam logic [RateWidth-1:0] STEP_MINIMUM_RST    = 32'd1000;
   localparam logic [FracWidth-1:0] STEP_FRACTION_RST   = 16'd6554;
   localparam logic [FracWidth-1:0] STALE_THRESHOLD_RST = 16'd1000;
   localparam logic [RateWidth-1:0] DEFAULT_LIMIT_RST   = 32'd500000;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_FLOOR_RATE      = 3'd0,
      CSR_HEADROOM_SHARE  = 3'd1,
      CSR_DECREASE_FACTOR = 3'd2,
      CSR_LOSS_THRESHOLD  = 3'd3,
      CSR_STEP_MINIMUM    = 3'd4,
      CSR_STEP_FRACTION   = 3'd5,
      CSR_STALE_THRESHOLD = 3'd6,
      CSR_DEFAULT_LIMIT   = 3'd7
   } csr_idx_type;

   typedef enum logic {
      KIND_FEEDBACK  = 1'b0,
      KIND_SET_LIMIT = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type          kind;
      logic [RateWidth-1:0]   sent_rate;
      logic signed [31:0]     received_rate;
      logic signed [31:0]     duplicate_rate;
      logic                   report_nonfinite;
      logic                   ever_received;
      logic [FracWidth-1:0]   silence_ms;
      logic [RateWidth-1:0]   new_limit;
   } req_word_type;

   typedef struct packed {
      logic [RateWidth-1:0]   effective_cap_out;
      logic [RateWidth-1:0]   cap_setting_out;
      logic [GoodWidth-1:0]   goodput_out;
      logic                   congested;
      logic                   sample_unusable;
   } rsp_word_type;

endpackage

[design/aimd_arc_if.sv]
// Valid/ready channel interfaces for the request and response words.
interface aimd_arc_req_if import aimd_arc_pkg::*;;
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface aimd_arc_rsp_if import aimd_arc_pkg::*;;
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[design/aimd_admission_rate_control_core.sv]
// Top level of the AIMD admission rate control core.
//
//   Channel    Direction   Handshake        Word
//   req_chan   in          valid / ready    feedback sample or limit request
//   rsp_chan   out         valid / ready    cap, limit, goodput and flags
//   csr_*      in          write enable     one register write per cycle
//
// Each request word yields one response word, passing the s1, s2 and s3
// registers and the response register. One word can enter every cycle
// while no response stalls: the cap update stage, one shared Q0.16 multiply
// and a compare and select, closes the loop on the cap from its own register.
// Synchronous active-high reset loads the register defaults, cap and limit.
// A stalled response holds every full stage; empty stages ahead still fill.
module aimd_admission_rate_control_core import aimd_arc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   aimd_arc_req_if.sink           req_chan,
   aimd_arc_rsp_if.source         rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [RateWidth-1:0]   csr_wdata
);

   // Word after classification: flags, goodput and the limit request.
   typedef struct packed {
      item_kind_type          kind;
      logic [RateWidth-1:0]   new_limit;
      logic [GoodWidth-1:0]   goodput;
      logic                   congested;
      logic                   unusable;
   } cls_word_type;

   // -----------------------------------------------------------------------
   // Configuration registers.
   // -----------------------------------------------------------------------
   logic [RateWidth-1:0] floor_rate_ff;
   logic [FracWidth-1:0] headroom_share_ff;
   logic [FracWidth-1:0] decrease_factor_ff;
   logic [FracWidth-1:0] loss_threshold_ff;
   logic [RateWidth-1:0] step_minimum_ff;
   logic [FracWidth-1:0] step_fraction_ff;
   logic [FracWidth-1:0] stale_threshold_ff;
   logic [RateWidth-1:0] default_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_rate_ff      <= FLOOR_RATE_RST;
         headroom_share_ff  <= HEADROOM_SHARE_RST;
         decrease_factor_ff <= DECREASE_FACTOR_RST;
         loss_threshold_ff  <= LOSS_THRESHOLD_RST;
         step_minimum_ff    <= STEP_MINIMUM_RST;
         step_fraction_ff   <= STEP_FRACTION_RST;
         stale_threshold_ff <= STALE_THRESHOLD_RST;
         default_limit_ff   <= DEFAULT_LIMIT_RST;
      end else if (csr_write_en) begin
         // The 16-bit registers keep the low half of the write data.
         case (csr_idx_type'(csr_index))
            CSR_FLOOR_RATE:      floor_rate_ff      <= csr_wdata;
            CSR_HEADROOM_SHARE:  headroom_share_ff  <= csr_wdata[FracWidth-1:0];
            CSR_DECREASE_FACTOR: decrease_factor_ff <= csr_wdata[FracWidth-1:0];
            CSR_LOSS_THRESHOLD:  loss_threshold_ff  <= csr_wdata[FracWidth-1:0];
            CSR_STEP_MINIMUM:    step_minimum_ff    <= csr_wdata;
            CSR_STEP_FRACTION:   step_fraction_ff   <= csr_wdata[FracWidth-1:0];
            CSR_STALE_THRESHOLD: stale_threshold_ff <= csr_wdata[FracWidth-1:0];
            CSR_DEFAULT_LIMIT:   default_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // -----------------------------------------------------------------------
   // Pipeline flow control. Each stage moves on when the stage after it is
   // empty or moving; the response register holds the outgoing word.
   // -----------------------------------------------------------------------
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   logic         s2_valid_ff, s2_valid_in;
   cls_word_type s2_word_ff, s2_word_in;
   logic         s3_valid_ff, s3_valid_in;
   cls_word_type s3_word_ff;
   logic [RateWidth-1:0] s3_target_ff, s3_target_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic out_free, s3_free, s2_free, s1_free;
   logic s3_move, s2_move, s1_move, req_take;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign s3_move  = s3_valid_ff && out_free;
   assign s2_move  = s2_valid_ff && s3_free;
   assign s1_move  = s1_valid_ff && s2_free;
   assign req_take = req_chan.valid && s1_free;

   assign req_chan.ready = s1_free;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   always_comb begin
      s1_valid_in  = s1_free ? req_chan.valid : s1_valid_ff;
      s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = s3_free ? s2_valid_ff : s3_valid_ff;
      rsp_valid_in = out_free ? s3_valid_ff : rsp_valid_ff;
   end

   // -----------------------------------------------------------------------
   // Stage 1 to 2: judge the sample, find congestion and the goodput.
   // -----------------------------------------------------------------------
   logic                   stale, unusable, rec_neg;
   logic [FracWidth:0]     keep_share;
   logic [48:0]            thr_prod;
   logic [32:0]            thr;
   logic                   below_thr;
   logic signed [32:0]     diff, hi;
   logic [GoodWidth-1:0]   goodput;

   always_comb begin
      stale    = s1_word_ff.ever_received &&
                 (s1_word_ff.silence_ms >= stale_threshold_ff);
      rec_neg  = s1_word_ff.received_rate[31];
      unusable = stale || s1_word_ff.report_nonfinite || rec_neg ||
                 s1_word_ff.duplicate_rate[31] ||
                 (s1_word_ff.duplicate_rate > s1_word_ff.received_rate);

      // The received rate must reach (1 - loss_threshold) of the sent rate.
      keep_share = Q16_ONE - {1'b0, loss_threshold_ff};
      thr_prod   = {32'd0, keep_share} * {17'd0, s1_word_ff.sent_rate};
      thr        = thr_prod[48:16];
      below_thr  = rec_neg || ({2'b00, s1_word_ff.received_rate[30:0]} < thr);

      // Goodput is received minus duplicate, kept within 0 and received.
      diff = {s1_word_ff.received_rate[31], s1_word_ff.received_rate} -
             {s1_word_ff.duplicate_rate[31], s1_word_ff.duplicate_rate};
      hi   = rec_neg ? 33'sd0 : {1'b0, s1_word_ff.received_rate};
      if (s1_word_ff.report_nonfinite || diff[32]) begin
         goodput = '0;
      end else if (diff > hi) begin
         goodput = hi[GoodWidth-1:0];
      end else begin
         goodput = diff[GoodWidth-1:0];
      end

      s2_word_in.kind      = s1_word_ff.kind;
      s2_word_in.new_limit = s1_word_ff.new_limit;
      s2_word_in.goodput   = goodput;
      s2_word_in.unusable  = unusable;
      // An idle sender is never congested.
      s2_word_in.congested = (s1_word_ff.sent_rate != '0) && (unusable || below_thr);
   end

   // -----------------------------------------------------------------------
   // Stage 2 to 3: headroom target, the share of goodput the cap may keep.
   // -----------------------------------------------------------------------
   logic [FracWidth-1:0] share_sat;
   logic [FracWidth:0]   free_share;
   logic [47:0]          tgt_prod;

   always_comb begin
      share_sat    = (headroom_share_ff > HEADROOM_MAX) ? HEADROOM_MAX : headroom_share_ff;
      free_share   = Q16_ONE - {1'b0, share_sat};
      tgt_prod     = {31'd0, free_share} * {17'd0, s2_word_ff.goodput};
      s3_target_in = tgt_prod[47:16];
   end

   // -----------------------------------------------------------------------
   // Stage 3 to response: update the cap state. One multiplier serves both
   // the decrease (decrease_factor) and the increase step (step_fraction).
   // -----------------------------------------------------------------------
   logic [RateWidth-1:0] eff_cap_ff, eff_cap_in;
   logic [RateWidth-1:0] cap_set_ff, cap_set_in;
   logic [GoodWidth-1:0] last_good_ff, last_good_in;

   logic [FracWidth-1:0] mul_frac;
   logic [47:0]          cap_prod;
   logic [RateWidth-1:0] scaled, cut, flo, step, limit_req;
   logic [RateWidth:0]   sum;
   logic [RateWidth-1:0] fb_cap;

   always_comb begin
      mul_frac = s3_word_ff.congested ? decrease_factor_ff : step_fraction_ff;
      cap_prod = {32'd0, mul_frac} * {16'd0, eff_cap_ff};
      scaled   = cap_prod[47:16];

      // Congestion: cut, aim at the headroom target if the report is usable,
      // and never drop under min(floor, limit).
      flo = (floor_rate_ff < cap_set_ff) ? floor_rate_ff : cap_set_ff;
      cut = scaled;
      if (!s3_word_ff.unusable && (s3_target_ff < scaled)) begin
         cut = s3_target_ff;
      end

      // Clean sample: add at least the minimum step, up to the limit.
      step = (scaled < step_minimum_ff) ? step_minimum_ff : scaled;
      sum  = {1'b0, eff_cap_ff} + {1'b0, step};

      if (s3_word_ff.congested) begin
         fb_cap = (cut > flo) ? cut : flo;
      end else if (sum < {1'b0, cap_set_ff}) begin
         fb_cap = sum[RateWidth-1:0];
      end else begin
         fb_cap = cap_set_ff;
      end

      limit_req = (s3_word_ff.new_limit == '0) ? default_limit_ff : s3_word_ff.new_limit;

      eff_cap_in   = eff_cap_ff;
      cap_set_in   = cap_set_ff;
      last_good_in = last_good_ff;
      rsp_word_in  = rsp_word_ff;

      if (s3_move) begin
         if (s3_word_ff.kind == KIND_SET_LIMIT) begin
            cap_set_in = limit_req;
            // A cap with no backoff follows the limit; otherwise it is clamped.
            if (eff_cap_ff >= cap_set_ff || limit_req < eff_cap_ff) begin
               eff_cap_in = limit_req;
            end
         end else begin
            eff_cap_in   = fb_cap;
            last_good_in = s3_word_ff.goodput;
         end
         rsp_word_in.effective_cap_out = eff_cap_in;
         rsp_word_in.cap_setting_out   = cap_set_in;
         rsp_word_in.goodput_out       = last_good_in;
         rsp_word_in.congested         = (s3_word_ff.kind == KIND_FEEDBACK) &&
                                         s3_word_ff.congested;
         rsp_word_in.sample_unusable   = (s3_word_ff.kind == KIND_FEEDBACK) &&
                                         s3_word_ff.unusable;
      end
   end

   // -----------------------------------------------------------------------
   // Registers.
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         eff_cap_ff   <= DEFAULT_LIMIT_RST;
         cap_set_ff   <= DEFAULT_LIMIT_RST;
         last_good_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         eff_cap_ff   <= eff_cap_in;
         cap_set_ff   <= cap_set_in;
         last_good_ff <= last_good_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_chan.data;
      end
      if (s1_move) begin
         s2_word_ff <= s2_word_in;
      end
      if (s2_move) begin
         s3_word_ff   <= s2_word_ff;
         s3_target_ff <= s3_target_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

endmodule

[test/aimd_admission_rate_control_core_test.sv]
// Self-checking testbench for the AIMD admission rate control core.
module aimd_admission_rate_control_core_test;
   import aimd_arc_pkg::*;

   // The longest stretch of cycles in which no word moves on either channel.
   // The receiver stalls only at random and never for good, so a run of
   // QuietLimit quiet cycles can only mean the block has hung.
   localparam int QuietLimit    = 3000;
   localparam int EpochCount    = 9;
   localparam int WordsPerEpoch = 81;
   // A word passes the block's pipeline registers before its response leaves;
   // the settle wait lets any stray response show up before the verdict.
   localparam int SettleCycles  = 8;

   // Predicts the cap, limit and goodput after each request word and holds
   // the predicted response words in arrival order.
   class cap_scoreboard;
      logic [RateWidth-1:0] floor_rate;
      logic [FracWidth-1:0] headroom_share;
      logic [FracWidth-1:0] decrease_factor;
      logic [FracWidth-1:0] loss_threshold;
      logic [RateWidth-1:0] step_minimum;
      logic [FracWidth-1:0] step_fraction;
      logic [FracWidth-1:0] stale_ms;
      logic [RateWidth-1:0] default_limit;

      logic [RateWidth-1:0] cap;
      logic [RateWidth-1:0] setting;
      logic [GoodWidth-1:0] last_good;

      rsp_word_type cap_words_due[$];
      int           mismatch_count;
      int           word_count;

      function new();
         floor_rate      = FLOOR_RATE_RST;
         headroom_share  = HEADROOM_SHARE_RST;
         decrease_factor = DECREASE_FACTOR_RST;
         loss_threshold  = LOSS_THRESHOLD_RST;
         step_minimum    = STEP_MINIMUM_RST;
         step_fraction   = STEP_FRACTION_RST;
         stale_ms        = STALE_THRESHOLD_RST;
         default_limit   = DEFAULT_LIMIT_RST;
         cap             = DEFAULT_LIMIT_RST;
         setting         = DEFAULT_LIMIT_RST;
         last_good       = '0;
         mismatch_count  = 0;
         word_count      = 0;
      endfunction

      function void write_register(csr_idx_type idx, logic [RateWidth-1:0] value);
         case (idx)
            CSR_FLOOR_RATE:      floor_rate      = value;
            CSR_HEADROOM_SHARE:  headroom_share  = value[FracWidth-1:0];
            CSR_DECREASE_FACTOR: decrease_factor = value[FracWidth-1:0];
            CSR_LOSS_THRESHOLD:  loss_threshold  = value[FracWidth-1:0];
            CSR_STEP_MINIMUM:    step_minimum    = value;
            CSR_STEP_FRACTION:   step_fraction   = value[FracWidth-1:0];
            CSR_STALE_THRESHOLD: stale_ms        = value[FracWidth-1:0];
            CSR_DEFAULT_LIMIT:   default_limit   = value;
            default: ;
         endcase
      endfunction

      function int outstanding();
         return cap_words_due.size();
      endfunction

      // Exact Q0.16 product, truncated.
      function longint scale_q16(longint frac, longint rate);
         return (frac * rate) >>> 16;
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type         r;
         longint               sent;
         longint               rec;
         longint               dup;
         longint               good;
         longint               hi;
         longint               cut;
         longint               target;
         longint               stepv;
         longint               sum;
         logic [RateWidth-1:0] old;
         logic [RateWidth-1:0] flo;
         logic [FracWidth-1:0] hr;
         logic                 stale;
         logic                 unusable;
         logic                 cong;

         sent     = longint'(w.sent_rate);
         rec      = longint'($signed(w.received_rate));
         dup      = longint'($signed(w.duplicate_rate));
         unusable = 1'b0;
         cong     = 1'b0;
         if (w.kind == KIND_SET_LIMIT) begin
            old     = setting;
            setting = (w.new_limit == '0) ? default_limit : w.new_limit;
            // A cap that was never backed off follows the new limit.
            if (cap >= old) cap = setting;
            else if (setting < cap) cap = setting;
         end else begin
            stale    = w.ever_received && (w.silence_ms >= stale_ms);
            unusable = stale || w.report_nonfinite || rec < 0 || dup < 0 || dup > rec;
            if (sent > 0)
               cong = unusable ||
                      rec < scale_q16(longint'(65536 - loss_threshold), sent);
            if (w.report_nonfinite) begin
               good = 0;
            end else begin
               hi   = (rec > 0) ? rec : 0;
               good = rec - dup;
               if (good < 0) good = 0;
               if (good > hi) good = hi;
            end
            last_good = good[GoodWidth-1:0];
            flo = (floor_rate < setting) ? floor_rate : setting;
            if (cong) begin
               cut = scale_q16(longint'(decrease_factor), longint'(cap));
               if (!unusable) begin
                  hr     = (headroom_share > HEADROOM_MAX) ? HEADROOM_MAX : headroom_share;
                  target = scale_q16(longint'(65536 - hr), longint'(last_good));
                  if (target < cut) cut = target;
               end
               cap = (cut > longint'(flo)) ? cut[RateWidth-1:0] : flo;
            end else begin
               stepv = scale_q16(longint'(step_fraction), longint'(cap));
               if (stepv < longint'(step_minimum)) stepv = longint'(step_minimum);
               sum = longint'(cap) + stepv;
               cap = (sum < longint'(setting)) ? sum[RateWidth-1:0] : setting;
            end
         end
         r.effective_cap_out = cap;
         r.cap_setting_out   = setting;
         r.goodput_out       = last_good;
         r.congested         = cong;
         r.sample_unusable   = unusable;
         cap_words_due.insert(cap_words_due.size(), r);
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         $display("mismatch: %s", msg);
      endtask

      task check_response(rsp_word_type got);
         rsp_word_type want;
         if (cap_words_due.size() == 0) begin
            report_mismatch($sformatf("response word with none outstanding, cap %0d",
                                      got.effective_cap_out));
            return;
         end
         want = cap_words_due.pop_front();
         word_count++;
         if (got.effective_cap_out !== want.effective_cap_out)
            report_mismatch($sformatf("word %0d effective_cap_out %0d, predicted %0d",
                            word_count, got.effective_cap_out, want.effective_cap_out));
         if (got.cap_setting_out !== want.cap_setting_out)
            report_mismatch($sformatf("word %0d cap_setting_out %0d, predicted %0d",
                            word_count, got.cap_setting_out, want.cap_setting_out));
         if (got.goodput_out !== want.goodput_out)
            report_mismatch($sformatf("word %0d goodput_out %0d, predicted %0d",
                            word_count, got.goodput_out, want.goodput_out));
         if (got.congested !== want.congested)
            report_mismatch($sformatf("word %0d congested %b, predicted %b",
                            word_count, got.congested, want.congested));
         if (got.sample_unusable !== want.sample_unusable)
            report_mismatch($sformatf("word %0d sample_unusable %b, predicted %b",
                            word_count, got.sample_unusable, want.sample_unusable));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [RateWidth-1:0]   csr_wdata;

   aimd_arc_req_if req_if ();
   aimd_arc_rsp_if rsp_if ();

   cap_scoreboard sb;
   int            send_idle_pct;
   int            recv_idle_pct;
   int            quiet_cycles = 0;

   // Configuration sets visited by the epochs: typical, all ones, all zeros,
   // raw random, zero default limit and the reset values.
   int epoch_mode[EpochCount] = '{0, 1, 2, 3, 0, 4, 3, 1, 5};

   aimd_admission_rate_control_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // The receiver decides at every falling edge whether to stall the next cycle.
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Response words are checked at the rising edge that moves them.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         sb.check_response(rsp_if.data);
   end

   // A hung block shows as a long run of cycles with no word moving.
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offers one request word from a falling edge on, after a random number
   // of idle cycles, and returns at the falling edge after it was taken.
   // Valid is left high so that back-to-back words keep it up without a dip.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      sb.note_request(w);
      @(negedge clock);
   endtask

   // Holds the sender off until every predicted response word has arrived.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   task automatic write_register(input csr_idx_type idx, input logic [RateWidth-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      sb.write_register(idx, value);
      @(negedge clock);
   endtask

   // Writes all eight registers; only called while the block is idle.
   task automatic configure(input int mode);
      logic [RateWidth-1:0] v[8];
      case (mode)
         0: begin
            v[0] = $urandom_range(0, 200000);
            v[1] = $urandom_range(0, 65535);
            v[2] = $urandom_range(16384, 60000);
            v[3] = $urandom_range(0, 20000);
            v[4] = $urandom_range(0, 50000);
            v[5] = $urandom_range(0, 20000);
            v[6] = $urandom_range(0, 3000);
            v[7] = $urandom_range(1, 4000000);
         end
         1: begin
            v[0] = '1; v[1] = 32'h0000_FFFF; v[2] = 32'h0000_FFFF; v[3] = 32'h0000_FFFF;
            v[4] = '1; v[5] = 32'h0000_FFFF; v[6] = 32'h0000_FFFF; v[7] = '1;
         end
         2, 4: begin
            v[0] = '0; v[1] = '0; v[2] = '0; v[3] = '0;
            v[4] = '0; v[5] = '0; v[6] = '0;
            // A zero default limit turns a zero request into a zero limit.
            v[7] = (mode == 4) ? 32'd0 : 32'd1;
         end
         3: begin
            v[0] = $urandom; v[1] = $urandom; v[2] = $urandom; v[3] = $urandom;
            v[4] = $urandom; v[5] = $urandom; v[6] = $urandom; v[7] = $urandom;
         end
         default: begin
            v[0] = FLOOR_RATE_RST;                  v[1] = RateWidth'(HEADROOM_SHARE_RST);
            v[2] = RateWidth'(DECREASE_FACTOR_RST); v[3] = RateWidth'(LOSS_THRESHOLD_RST);
            v[4] = STEP_MINIMUM_RST;                v[5] = RateWidth'(STEP_FRACTION_RST);
            v[6] = RateWidth'(STALE_THRESHOLD_RST); v[7] = DEFAULT_LIMIT_RST;
         end
      endcase
      // The 16-bit registers only keep the low half of the data.
      for (int i = 1; i <= 6; i++)
         if (i != 4) v[i] = {16'd0, v[i][FracWidth-1:0]};
      write_register(CSR_FLOOR_RATE,      v[0]);
      write_register(CSR_HEADROOM_SHARE,  v[1]);
      write_register(CSR_DECREASE_FACTOR, v[2]);
      write_register(CSR_LOSS_THRESHOLD,  v[3]);
      write_register(CSR_STEP_MINIMUM,    v[4]);
      write_register(CSR_STEP_FRACTION,   v[5]);
      write_register(CSR_STALE_THRESHOLD, v[6]);
      write_register(CSR_DEFAULT_LIMIT,   v[7]);
      csr_write_en <= 1'b0;
   endtask

   function automatic req_word_type make_word(
      input item_kind_type      kind,
      input logic [31:0]        sent,
      input logic signed [31:0] rec,
      input logic signed [31:0] dup,
      input logic               nonfinite,
      input logic               ever,
      input logic [15:0]        silence,
      input logic [31:0]        limit
   );
      req_word_type w;
      w.kind             = kind;
      w.sent_rate        = sent;
      w.received_rate    = rec;
      w.duplicate_rate   = dup;
      w.report_nonfinite = nonfinite;
      w.ever_received    = ever;
      w.silence_ms       = silence;
      w.new_limit        = limit;
      return w;
   endfunction

   // Mostly plausible feedback around random rates, with congested and
   // unusable samples, limit changes and some raw noise mixed in.
   function automatic req_word_type random_word();
      req_word_type w;
      int           pick;
      logic [31:0]  sent;
      logic [31:0]  rec;
      pick = $urandom_range(99);
      w    = make_word(KIND_FEEDBACK, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                       1'($urandom_range(1)), 16'($urandom), $urandom);
      if (pick < 12) begin
         w.kind = KIND_SET_LIMIT;
         case ($urandom_range(3))
            0: w.new_limit = '0;
            1: w.new_limit = $urandom;
            2: w.new_limit = $urandom >> $urandom_range(0, 31);
            default: w.new_limit = $urandom_range(1000, 3000000);
         endcase
      end else if (pick >= 20) begin
         sent = ($urandom_range(19) == 0) ? 32'd0 : ($urandom >> $urandom_range(1, 24));
         w.sent_rate        = sent;
         w.report_nonfinite = 1'b0;
         w.ever_received    = ($urandom_range(9) != 0);
         case ($urandom_range(19))
            0:       w.silence_ms = 16'hFFFF;
            1, 2:    w.silence_ms = 16'($urandom);
            default: w.silence_ms = 16'($urandom_range(0, 1200));
         endcase
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               rec = sent - (sent >> $urandom_range(4, 31));
               w.received_rate  = rec;
               w.duplicate_rate = rec >> $urandom_range(3, 31);
            end
            5, 6, 7: begin
               rec = sent >> $urandom_range(1, 8);
               w.received_rate  = rec;
               w.duplicate_rate = rec >> $urandom_range(1, 31);
            end
            8: begin
               rec = sent;
               w.received_rate  = rec;
               w.duplicate_rate = 0;
               case ($urandom_range(3))
                  0: w.report_nonfinite = 1'b1;
                  1: w.received_rate    = ~($urandom >> $urandom_range(1, 31));
                  2: w.duplicate_rate   = ~($urandom >> $urandom_range(1, 31));
                  default: w.duplicate_rate = rec + 1 + $urandom_range(0, 1000);
               endcase
            end
            default: begin
               rec = sent + $urandom_range(0, 100000);
               w.received_rate  = rec;
               w.duplicate_rate = $urandom_range(0, 1000);
            end
         endcase
      end
      return w;
   endfunction

   // Directed words, run with the reset register values. The comments give
   // the state the predictor expects on the way.
   task automatic directed_words();
      // Raise the limit to its maximum; the untouched cap follows it.
      send_word(make_word(KIND_SET_LIMIT, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
      // Idle link: nothing sent, so the cap tries to grow past 32 bits and
      // has to stop at the limit.
      send_word(make_word(KIND_FEEDBACK, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(KIND_SET_LIMIT, 0, 0, 0, 0, 0, 0, 1));
      // A zero request picks the default limit.
      send_word(make_word(KIND_SET_LIMIT, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(KIND_FEEDBACK, 100000, 100000, 0, 0, 1, 10, 0));
      // Usable congestion: the headroom target undercuts the plain decrease.
      send_word(make_word(KIND_FEEDBACK, 400000, 100000, 10000, 0, 1, 999, 0));
      // The cap is backed off and already below the new limit.
      send_word(make_word(KIND_SET_LIMIT, 0, 0, 0, 0, 0, 0, 300000));
      // Silence exactly at the threshold makes the sample stale.
      send_word(make_word(KIND_FEEDBACK, 1000, 1000, 0, 0, 1, 1000, 0));
      // Long silence counts for nothing before the first receive.
      send_word(make_word(KIND_FEEDBACK, 1000, 1000, 0, 0, 0, 16'hFFFF, 0));
      send_word(make_word(KIND_FEEDBACK, 5000, 5000, 0, 1, 1, 0, 0));
      send_word(make_word(KIND_FEEDBACK, 10, -1, 0, 0, 1, 0, 0));
      // Unusable, but with nothing sent it is still not congested.
      send_word(make_word(KIND_FEEDBACK, 0, 50, 32'sh8000_0000, 0, 1, 0, 0));
      send_word(make_word(KIND_FEEDBACK, 100, 100, 101, 0, 1, 0, 0));
      // Duplicates equal to receives: usable, zero goodput, cut to the floor.
      send_word(make_word(KIND_FEEDBACK, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          0, 1, 0, 0));
      send_word(make_word(KIND_FEEDBACK, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 1, 0, 0));
      send_word(make_word(KIND_FEEDBACK, 32'hFFFF_FFFF, 32'sh8000_0000, 0, 0, 1, 0, 0));
      // Negative duplicates: goodput is clamped to the received rate.
      send_word(make_word(KIND_FEEDBACK, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, 0, 0));
      send_word(make_word(KIND_SET_LIMIT, 0, 0, 0, 0, 0, 0, 250000));
      send_word(make_word(KIND_FEEDBACK, 0, 0, 0, 0, 1, 0, 0));
      send_word(make_word(KIND_FEEDBACK, 0, 0, 0, 0, 1, 0, 0));
      send_word(make_word(KIND_SET_LIMIT, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
      // One byte sent: the loss threshold truncates to zero, so no congestion.
      send_word(make_word(KIND_FEEDBACK, 1, 1, 0, 0, 1, 0, 0));
   endtask

   initial begin
      sb               = new();
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data      = '0;
      rsp_if.ready     = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_FLOOR_RATE;
      csr_wdata        = '0;
      send_idle_pct    = 22;
      recv_idle_pct    = 72;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_words();

      // Each epoch waits for the block to go idle, loads a new register set
      // and sends random words. Halfway through, the sender also holds off
      // until every response is in, so the pipeline empties under traffic.
      for (int epoch = 0; epoch < EpochCount; epoch++) begin
         if (epoch == EpochCount / 3) begin
            send_idle_pct = 72;
            recv_idle_pct = 22;
         end else if (epoch == 2 * EpochCount / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain_results();
         configure(epoch_mode[epoch]);
         for (int i = 0; i < WordsPerEpoch; i++) begin
            if (i == WordsPerEpoch / 2) drain_results();
            send_word(random_word());
         end
      end

      drain_results();
      repeat (SettleCycles) @(negedge clock);
      if (sb.mismatch_count == 0 && sb.outstanding() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
design/aimd_arc_pkg.sv
design/aimd_arc_if.sv
design/aimd_admission_rate_control_core.sv
test/aimd_admission_rate_control_core_test.sv
